>>> rtl/core/i2cbe_pkg.sv
// Package for the I2C master bit engine: command codes, controller states,
// and the command/status structs that join controller and datapath. No dependencies.
`default_nettype none
package i2cbe_pkg;

  localparam int unsigned HoldW = 16;
  localparam logic [HoldW-1:0] HoldReset = 16'd250;
  localparam logic [2:0] LastBit = 3'd7;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_WRBYTE = 3'd2,
    OP_RDBYTE = 3'd3,
    OP_TXACK  = 3'd4,
    OP_RXACK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_OUT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic write;
    logic tmr_load;
    logic tmr_dec;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_ok;
    logic last;
    logic tmr_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/i2cbe_ifs.sv
// Valid/ready channel interfaces for command beats and pin-write beats.
// Standalone; no package dependency.
`default_nettype none
interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic [7:0] line_samples;

  modport source (output valid, opcode, tx_byte, ack_to_send, line_samples, input ready);
  modport sink   (input valid, opcode, tx_byte, ack_to_send, line_samples, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       last_write;
  logic [7:0] rx_byte;
  logic       ack_received;

  modport source (output valid, scl_out, sda_out, last_write, rx_byte, ack_received,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, last_write, rx_byte, ack_received,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/i2cbe_ctrl.sv
// Controller state machine of the I2C bit engine.
// Depends on i2cbe_pkg for the state type and command/status structs.
`default_nettype none
module i2cbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire i2cbe_pkg::dp_stat_t stat,
  output i2cbe_pkg::ctl_cmd_t   cmd
);

  i2cbe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2cbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      i2cbe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // Unused opcodes are taken and dropped without any pin write.
        if (in_valid && stat.op_ok) begin
          cmd.load  = 1'b1;
          state_nxt = i2cbe_pkg::ST_EMIT;
        end
      end
      i2cbe_pkg::ST_EMIT: begin
        cmd.write = 1'b1;
        state_nxt = i2cbe_pkg::ST_OUT;
      end
      i2cbe_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.tmr_load = 1'b1;
          state_nxt    = i2cbe_pkg::ST_HOLD;
        end
      end
      i2cbe_pkg::ST_HOLD: begin
        if (stat.tmr_zero) begin
          state_nxt = stat.last ? i2cbe_pkg::ST_IDLE : i2cbe_pkg::ST_EMIT;
        end else begin
          cmd.tmr_dec = 1'b1;
        end
      end
      default: begin
        state_nxt = i2cbe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/i2cbe_dp.sv
// Datapath of the I2C bit engine: line levels, bit sequencing, hold timer,
// configuration register and the result register. Depends on i2cbe_pkg.
`default_nettype none
module i2cbe_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [2:0]                  in_opcode,
  input  wire logic [7:0]                  in_tx_byte,
  input  wire logic                        in_ack_to_send,
  input  wire logic [7:0]                  in_line_samples,
  input  wire logic                        cfg_we,
  input  wire logic [i2cbe_pkg::HoldW-1:0] cfg_wdata,
  input  wire i2cbe_pkg::ctl_cmd_t         cmd,
  output i2cbe_pkg::dp_stat_t              stat,
  output logic                             out_scl_out,
  output logic                             out_sda_out,
  output logic                             out_last_write,
  output logic [7:0]                       out_rx_byte,
  output logic                             out_ack_received
);

  logic [i2cbe_pkg::HoldW-1:0] hold_r, timer_r;
  logic                        scl_r, sda_r;
  logic [1:0]                  phase_r, phase_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  i2cbe_pkg::op_t              op_r;
  logic [7:0]                  tx_r, smp_r;
  logic                        ack_tx_r;
  logic                        o_scl_r, o_sda_r, o_last_r, o_ack_r;
  logic [7:0]                  o_rx_r;
  logic                        scl_nxt, sda_nxt, last_nxt, ack_nxt;
  logic [7:0]                  rx_nxt;

  // Pin write for the current step of the running command.
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    last_nxt  = 1'b0;
    rx_nxt    = 8'd0;
    ack_nxt   = 1'b0;
    phase_nxt = phase_r + 2'd1;
    bit_nxt   = bit_r;
    case (op_r)
      i2cbe_pkg::OP_START: begin
        case (phase_r)
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          2'd2:    sda_nxt = 1'b0;
          default: begin
            scl_nxt  = 1'b0;
            last_nxt = 1'b1;
          end
        endcase
      end
      i2cbe_pkg::OP_STOP: begin
        case (phase_r)
          2'd0:    sda_nxt = 1'b0;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            sda_nxt  = 1'b1;
            last_nxt = 1'b1;
          end
        endcase
      end
      i2cbe_pkg::OP_WRBYTE: begin
        case (phase_r)
          2'd0:    sda_nxt = tx_r[i2cbe_pkg::LastBit - bit_r];
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd0;
            bit_nxt   = bit_r + 3'd1;
            last_nxt  = (bit_r == i2cbe_pkg::LastBit);
          end
        endcase
      end
      i2cbe_pkg::OP_RDBYTE: begin
        case (phase_r)
          2'd0:    scl_nxt = 1'b1;
          default: begin
            // The assembled byte equals the sampled levels, shown on the final beat.
            scl_nxt   = 1'b0;
            phase_nxt = 2'd0;
            bit_nxt   = bit_r + 3'd1;
            last_nxt  = (bit_r == i2cbe_pkg::LastBit);
            rx_nxt    = last_nxt ? smp_r : 8'd0;
          end
        endcase
      end
      i2cbe_pkg::OP_TXACK: begin
        case (phase_r)
          2'd0:    sda_nxt = ack_tx_r;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt  = 1'b0;
            last_nxt = 1'b1;
          end
        endcase
      end
      i2cbe_pkg::OP_RXACK: begin
        case (phase_r)
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          default: begin
            scl_nxt  = 1'b0;
            last_nxt = 1'b1;
            ack_nxt  = smp_r[7];
          end
        endcase
      end
      default: begin
        last_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= i2cbe_pkg::HoldReset;
      timer_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      phase_r <= 2'd0;
      bit_r   <= 3'd0;
    end else begin
      if (cfg_we) begin
        hold_r <= cfg_wdata;
      end
      if (cmd.tmr_load) begin
        timer_r <= hold_r;
      end else if (cmd.tmr_dec) begin
        timer_r <= timer_r - i2cbe_pkg::HoldW'(1);
      end
      if (cmd.load) begin
        phase_r <= 2'd0;
        bit_r   <= 3'd0;
      end else if (cmd.write) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= i2cbe_pkg::op_t'(in_opcode);
      tx_r     <= in_tx_byte;
      smp_r    <= in_line_samples;
      ack_tx_r <= in_ack_to_send;
    end
    if (cmd.write) begin
      o_scl_r  <= scl_nxt;
      o_sda_r  <= sda_nxt;
      o_last_r <= last_nxt;
      o_rx_r   <= rx_nxt;
      o_ack_r  <= ack_nxt;
    end
  end

  assign stat.op_ok    = (in_opcode <= 3'(i2cbe_pkg::OP_RXACK));
  assign stat.last     = o_last_r;
  assign stat.tmr_zero = (timer_r == '0);

  assign out_scl_out      = o_scl_r;
  assign out_sda_out      = o_sda_r;
  assign out_last_write   = o_last_r;
  assign out_rx_byte      = o_rx_r;
  assign out_ack_received = o_ack_r;

endmodule
`default_nettype wire

>>> rtl/core/i2c_master_bit_engine_core.sv
// I2C master bit engine top level: one command beat in, a run of pin-write beats out.
// The first pin-write beat is registered in ST_EMIT once the command beat is taken
// and offered from ST_OUT; each write waits out output stalls in ST_OUT, then the
// hold timer, loaded with hold_cycles, in ST_HOLD. A command of N writes (3 to 24)
// ends before the next is taken. Unused opcodes are accepted and dropped. Synchronous
// active-low reset releases both lines and loads hold_cycles with 250; no clearing pass.
`default_nettype none
module i2c_master_bit_engine_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  i2cbe_in_if.sink                         in_ch,
  i2cbe_out_if.source                      out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [i2cbe_pkg::HoldW-1:0] cfg_wdata
);

  i2cbe_pkg::ctl_cmd_t cmd;
  i2cbe_pkg::dp_stat_t stat;

  i2cbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2cbe_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_ch.opcode),
    .in_tx_byte       (in_ch.tx_byte),
    .in_ack_to_send   (in_ch.ack_to_send),
    .in_line_samples  (in_ch.line_samples),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_scl_out      (out_ch.scl_out),
    .out_sda_out      (out_ch.sda_out),
    .out_last_write   (out_ch.last_write),
    .out_rx_byte      (out_ch.rx_byte),
    .out_ack_received (out_ch.ack_received)
  );

endmodule
`default_nettype wire

>>> rtl/core/i2cbe_checker.sv
// Port-level checker for the I2C bit engine, with its bind to the top level.
// Depends on i2cbe_pkg for the command codes.
`default_nettype none
module i2cbe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_scl_out,
  input wire logic       out_sda_out,
  input wire logic       out_last_write,
  input wire logic [7:0] out_rx_byte,
  input wire logic       out_ack_received
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl_out) && $stable(out_sda_out)
      && $stable(out_last_write) && $stable(out_rx_byte) && $stable(out_ack_received))
    else $error("result beat changed while stalled");

  // Commands are taken only when no result beat is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("command accepted while a result is pending");

  // A real command blocks the input until its run is finished.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode <= 3'(i2cbe_pkg::OP_RXACK)) |=> !in_ready)
    else $error("input ready right after a command was taken");

  // Received data shows only on the final beat of a run.
  a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_write |-> (out_rx_byte == 8'd0) && !out_ack_received)
    else $error("received data on a non-final beat");

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_scl_out      (out_ch.scl_out),
  .out_sda_out      (out_ch.sda_out),
  .out_last_write   (out_ch.last_write),
  .out_rx_byte      (out_ch.rx_byte),
  .out_ack_received (out_ch.ack_received)
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the I2C master bit engine: drives command beats, predicts every pin-write beat.
// Depends on i2cbe_pkg, the i2cbe_in_if and i2cbe_out_if interfaces and the core top level.

typedef struct packed {
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic [7:0] line_samples;
} i2c_cmd_t;

typedef struct packed {
  logic       scl;
  logic       sda;
  logic       last_write;
  logic [7:0] rx_byte;
  logic       ack_received;
} pin_write_t;

// Tracks the bus levels the master should be driving and queues the pin writes
// each accepted command will produce.
class pin_write_tracker;
  logic       scl_level;
  logic       sda_level;
  pin_write_t expected_writes[$];
  int         failures;

  function new();
    scl_level = 1'b1;
    sda_level = 1'b1;
    failures  = 0;
  endfunction

  function void add_write(logic last, logic [7:0] rx, logic ack);
    pin_write_t w;
    w.scl          = scl_level;
    w.sda          = sda_level;
    w.last_write   = last;
    w.rx_byte      = rx;
    w.ack_received = ack;
    expected_writes.push_back(w);
  endfunction

  function void note_command(i2c_cmd_t c);
    logic [7:0] assembled;
    int         i;
    assembled = 8'h00;
    case (c.opcode)
      i2cbe_pkg::OP_START: begin
        sda_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
        sda_level = 1'b0; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b0; add_write(1'b1, 8'h00, 1'b0);
      end
      i2cbe_pkg::OP_STOP: begin
        sda_level = 1'b0; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
        sda_level = 1'b1; add_write(1'b1, 8'h00, 1'b0);
      end
      i2cbe_pkg::OP_WRBYTE: begin
        for (i = 7; i >= 0; i--) begin
          sda_level = c.tx_byte[i]; add_write(1'b0, 8'h00, 1'b0);
          scl_level = 1'b1;         add_write(1'b0, 8'h00, 1'b0);
          scl_level = 1'b0;         add_write(i == 0, 8'h00, 1'b0);
        end
      end
      i2cbe_pkg::OP_RDBYTE: begin
        // SDA is left wherever it was; the slave's levels come from line_samples.
        for (i = 7; i >= 0; i--) begin
          scl_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
          assembled[i] = c.line_samples[i];
          scl_level = 1'b0;
          add_write(i == 0, (i == 0) ? assembled : 8'h00, 1'b0);
        end
      end
      i2cbe_pkg::OP_TXACK: begin
        sda_level = c.ack_to_send; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b1;          add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b0;          add_write(1'b1, 8'h00, 1'b0);
      end
      i2cbe_pkg::OP_RXACK: begin
        sda_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b1; add_write(1'b0, 8'h00, 1'b0);
        scl_level = 1'b0; add_write(1'b1, 8'h00, c.line_samples[7]);
      end
      default: ;
    endcase
  endfunction

  function void check_write(pin_write_t got);
    pin_write_t exp_w;
    if (expected_writes.size() == 0) begin
      if (failures < 10)
        $display("pin write beat with none pending: scl %0b sda %0b last %0b rx %02h ack %0b",
                 got.scl, got.sda, got.last_write, got.rx_byte, got.ack_received);
      failures++;
    end else begin
      exp_w = expected_writes.pop_front();
      if (got.scl !== exp_w.scl || got.sda !== exp_w.sda ||
          got.last_write !== exp_w.last_write || got.rx_byte !== exp_w.rx_byte ||
          got.ack_received !== exp_w.ack_received) begin
        if (failures < 10)
          $display("pin write mismatch: exp scl %0b sda %0b last %0b rx %02h ack %0b,",
                   exp_w.scl, exp_w.sda, exp_w.last_write, exp_w.rx_byte,
                   exp_w.ack_received,
                   " got scl %0b sda %0b last %0b rx %02h ack %0b",
                   got.scl, got.sda, got.last_write, got.rx_byte, got.ack_received);
        failures++;
      end
    end
  endfunction

  function int pending();
    return expected_writes.size();
  endfunction
endclass

module tb;
  localparam int NoBeatLimit = 250000;
  localparam int HoldOffLen = 400;
  localparam logic [2:0] OpUnused6 = 3'd6;
  localparam logic [2:0] OpUnused7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  i2cbe_in_if  in_ch ();
  i2cbe_out_if out_ch ();

  i2c_master_bit_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pin_write_tracker tracker = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_now = 250;
  int cmds_sent = 0;
  int hold_off_requests = 0;
  int no_beat_cycles = 0;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_off_served;
    int hold_off_left;
    hold_off_served = 0;
    hold_off_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_requests != hold_off_served) begin
        hold_off_served = hold_off_requests;
        hold_off_left = HoldOffLen;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_write({out_ch.scl_out, out_ch.sda_out, out_ch.last_write,
                           out_ch.rx_byte, out_ch.ack_received});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      no_beat_cycles <= 0;
    end else if (no_beat_cycles >= NoBeatLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      no_beat_cycles <= no_beat_cycles + 1;
    end
  end

  function automatic i2c_cmd_t make_cmd(logic [2:0] op, logic [7:0] tx, logic ack,
                                        logic [7:0] samples);
    i2c_cmd_t c;
    c.opcode       = op;
    c.tx_byte      = tx;
    c.ack_to_send  = ack;
    c.line_samples = samples;
    return c;
  endfunction

  function automatic i2c_cmd_t rand_cmd(logic [2:0] op);
    return make_cmd(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    8'($urandom_range(255)));
  endfunction

  task automatic send_cmd(input i2c_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= c.opcode;
    in_ch.tx_byte      <= c.tx_byte;
    in_ch.ack_to_send  <= c.ack_to_send;
    in_ch.line_samples <= c.line_samples;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_command(c);
    if (c.opcode <= i2cbe_pkg::OP_RXACK) cmds_sent++;
  endtask

  // A bus transaction: address, acked data bytes, stop. Some are cut short or
  // left without their stop so that a repeated start follows.
  task automatic send_transaction();
    logic [7:0] addr;
    int         n_bytes;
    int         i;
    addr = 8'($urandom_range(255));
    n_bytes = int'($urandom_range(1, 3));
    send_cmd(rand_cmd(i2cbe_pkg::OP_START));
    send_cmd(make_cmd(i2cbe_pkg::OP_WRBYTE, addr, 1'($urandom_range(1)),
                      8'($urandom_range(255))));
    send_cmd(rand_cmd(i2cbe_pkg::OP_RXACK));
    if ($urandom_range(99) < 10) n_bytes = 0;
    for (i = 0; i < n_bytes; i++) begin
      if (addr[0]) begin
        send_cmd(rand_cmd(i2cbe_pkg::OP_RDBYTE));
        send_cmd(make_cmd(i2cbe_pkg::OP_TXACK, 8'($urandom_range(255)), i == n_bytes - 1,
                          8'($urandom_range(255))));
      end else begin
        send_cmd(rand_cmd(i2cbe_pkg::OP_WRBYTE));
        send_cmd(rand_cmd(i2cbe_pkg::OP_RXACK));
      end
    end
    if ($urandom_range(99) >= 15) send_cmd(rand_cmd(i2cbe_pkg::OP_STOP));
  endtask

  task automatic run_random(input int count);
    int target;
    target = cmds_sent + count;
    while (cmds_sent < target) begin
      if ($urandom_range(99) < 75) send_transaction();
      else send_cmd(rand_cmd(3'($urandom_range(7))));
    end
  endtask

  // Waits until every pin write has arrived and the last hold time has run out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (hold_now + 8) @(posedge clk);
  endtask

  task automatic set_hold(input logic [15:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_now = int'(value);
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= i2cbe_pkg::OP_START;
    in_ch.tx_byte      <= '0;
    in_ch.ack_to_send  <= 1'b0;
    in_ch.line_samples <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset hold time.
    send_cmd(make_cmd(i2cbe_pkg::OP_START, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_WRBYTE, 8'h00, 1'b1, 8'hFF));
    send_cmd(make_cmd(i2cbe_pkg::OP_RXACK, 8'hFF, 1'b0, 8'h7F));
    send_cmd(make_cmd(i2cbe_pkg::OP_WRBYTE, 8'hFF, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_RXACK, 8'h00, 1'b1, 8'h80));
    send_cmd(make_cmd(i2cbe_pkg::OP_WRBYTE, 8'hA5, 1'b0, 8'h5A));
    send_cmd(make_cmd(i2cbe_pkg::OP_RDBYTE, 8'hFF, 1'b1, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_TXACK, 8'h00, 1'b0, 8'hFF));
    // SDA is still driven low by the ack when this read begins.
    send_cmd(make_cmd(i2cbe_pkg::OP_RDBYTE, 8'h00, 1'b0, 8'hFF));
    send_cmd(make_cmd(i2cbe_pkg::OP_TXACK, 8'hFF, 1'b1, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_RDBYTE, 8'h3C, 1'b1, 8'h5A));
    send_cmd(make_cmd(OpUnused6, 8'hFF, 1'b1, 8'hFF));
    send_cmd(make_cmd(OpUnused7, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_STOP, 8'h81, 1'b1, 8'h81));
    send_cmd(make_cmd(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_START, 8'hFF, 1'b1, 8'hFF));
    send_cmd(make_cmd(i2cbe_pkg::OP_START, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_RXACK, 8'h00, 1'b0, 8'h00));
    send_cmd(make_cmd(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 8'h00));

    set_hold(16'd0);
    run_random(18);

    set_hold(16'd1);
    send_idle_pct = 52;
    run_random(18);

    set_hold(16'd3);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    hold_off_requests++;
    run_random(18);

    set_hold(16'($urandom_range(2, 12)));
    send_idle_pct = 8;
    recv_stall_pct = 8;
    run_random(18);

    set_hold(16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cmd(rand_cmd(i2cbe_pkg::OP_STOP));

    wait_idle();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
